[design/svpwm_pkg.sv]
// shared types and constants for the space vector pwm timing block
package svpwm_pkg;

   // sector number of the voltage vector, one to six
   typedef enum logic [2:0] {
      SECTOR_1 = 3'd1,
      SECTOR_2 = 3'd2,
      SECTOR_3 = 3'd3,
      SECTOR_4 = 3'd4,
      SECTOR_5 = 3'd5,
      SECTOR_6 = 3'd6
   } sector_type;

   // 1/sqrt3 with 18 fractional bits, nearest to the exact value
   localparam int INV_SQRT3_Q18 = 151349;
   // signed width of the coefficient and its fractional bits
   localparam int COEF_WIDTH = 19;
   localparam int COEF_FRAC = 18;

   // entries in the queue between classification and timing
   localparam int QUEUE_DEPTH = 4;

   // timer top count after reset
   localparam int HALF_PERIOD_RESET = 10000;

endpackage

[design/svpwm_front.sv]
// front end: takes vector items, finds the sector and forms the two on-time combinations
module svpwm_front #(
   parameter int VEC_WIDTH = 16
) (
   input  logic                                           clock,
   input  logic                                           reset,
   input  logic                                           req_valid,
   output logic                                           req_stall,
   input  logic signed [VEC_WIDTH-1:0]                    req_alpha,
   input  logic signed [VEC_WIDTH-1:0]                    req_beta,
   input  logic                                           queue_full,
   output logic                                           push,
   output svpwm_pkg::sector_type                          push_sector,
   output logic signed [VEC_WIDTH+svpwm_pkg::COEF_WIDTH-1:0] push_x,
   output logic signed [VEC_WIDTH+svpwm_pkg::COEF_WIDTH-1:0] push_y
);
   import svpwm_pkg::*;

   localparam int LW = VEC_WIDTH + COEF_WIDTH;
   localparam logic signed [COEF_WIDTH-1:0] INV_COEF = COEF_WIDTH'(INV_SQRT3_Q18);

   logic                        f1_valid_ff, f1_valid_in;
   logic signed [VEC_WIDTH-1:0] alpha_ff, alpha_in;
   logic signed [LW-1:0]        b_ff, b_in;
   logic                        take;
   logic signed [LW-1:0]        a_lin, b2_lin, nb_lin;
   sector_type                  sector;

   // an item waits in the stage register while the queue is full
   assign req_stall = f1_valid_ff && queue_full;
   assign take      = req_valid && !req_stall;
   assign push      = f1_valid_ff && !queue_full;

   // input stage: beta scaled by 1/sqrt3
   always_comb begin
      alpha_in    = alpha_ff;
      b_in        = b_ff;
      f1_valid_in = f1_valid_ff;
      if (take) begin
         alpha_in    = req_alpha;
         b_in        = req_beta * INV_COEF;
         f1_valid_in = 1'b1;
      end else if (push) begin
         f1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
      end else begin
         f1_valid_ff <= f1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      alpha_ff <= alpha_in;
      b_ff     <= b_in;
   end

   // sector from quadrant and alpha against beta/sqrt3
   always_comb begin
      a_lin  = LW'(alpha_ff) <<< COEF_FRAC;
      b2_lin = b_ff <<< 1;
      nb_lin = -b_ff;
      if (!b_ff[LW-1]) begin
         if (!alpha_ff[VEC_WIDTH-1]) begin
            sector = (b_ff > a_lin) ? SECTOR_2 : SECTOR_1;
         end else begin
            sector = (nb_lin > a_lin) ? SECTOR_3 : SECTOR_2;
         end
      end else begin
         if (!alpha_ff[VEC_WIDTH-1]) begin
            sector = (nb_lin > a_lin) ? SECTOR_5 : SECTOR_6;
         end else begin
            sector = (b_ff > a_lin) ? SECTOR_4 : SECTOR_5;
         end
      end
   end

   // active vector combinations for the sector
   always_comb begin
      push_sector = sector;
      unique case (sector)
         SECTOR_1: begin
            push_x = a_lin - b_ff;
            push_y = b2_lin;
         end
         SECTOR_2: begin
            push_x = a_lin + b_ff;
            push_y = b_ff - a_lin;
         end
         SECTOR_3: begin
            push_x = b2_lin;
            push_y = nb_lin - a_lin;
         end
         SECTOR_4: begin
            push_x = b_ff - a_lin;
            push_y = -b2_lin;
         end
         SECTOR_5: begin
            push_x = nb_lin - a_lin;
            push_y = a_lin - b_ff;
         end
         default: begin
            push_x = -b2_lin;
            push_y = a_lin + b_ff;
         end
      endcase
   end

endmodule

[design/svpwm_queue.sv]
// short fifo of classified items between front and back end
module svpwm_queue #(
   parameter int DATA_WIDTH = 73,
   parameter int DEPTH      = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  logic [DATA_WIDTH-1:0] push_data,
   output logic                  full,
   input  logic                  pop,
   output logic [DATA_WIDTH-1:0] pop_data,
   output logic                  empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [DATA_WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]         wptr_ff, wptr_in;
   logic [PW-1:0]         rptr_ff, rptr_in;
   logic [CW-1:0]         count_ff, count_in;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = mem_ff[rptr_ff];

   // pointer and fill count update
   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff + CW'(push) - CW'(pop);
      if (push) begin
         wptr_in = (wptr_ff == PW'(DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
      end
      if (pop) begin
         rptr_in = (rptr_ff == PW'(DEPTH - 1)) ? '0 : rptr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wptr_ff] <= push_data;
      end
   end

endmodule

[design/svpwm_back.sv]
// back end: on-time products, zero-time split, phase ordering and saturation
module svpwm_back #(
   parameter int VEC_WIDTH   = 16,
   parameter int TIMER_WIDTH = 16
) (
   input  logic                                              clock,
   input  logic                                              reset,
   input  logic [TIMER_WIDTH-1:0]                            half_period,
   input  logic                                              queue_empty,
   output logic                                              pop,
   input  svpwm_pkg::sector_type                             pop_sector,
   input  logic signed [VEC_WIDTH+svpwm_pkg::COEF_WIDTH-1:0] pop_x,
   input  logic signed [VEC_WIDTH+svpwm_pkg::COEF_WIDTH-1:0] pop_y,
   output logic                                              rsp_valid,
   input  logic                                              rsp_stall,
   output logic [TIMER_WIDTH-1:0]                            rsp_duty_a,
   output logic [TIMER_WIDTH-1:0]                            rsp_duty_b,
   output logic [TIMER_WIDTH-1:0]                            rsp_duty_c,
   output logic [2:0]                                        rsp_sector
);
   import svpwm_pkg::*;

   localparam int LW    = VEC_WIDTH + COEF_WIDTH;
   localparam int MW    = LW - 1;
   localparam int H     = MW / 2;
   localparam int HW    = MW - H;
   localparam int T     = TIMER_WIDTH;
   localparam int PRW   = MW + T;
   localparam int SHIFT = VEC_WIDTH - 2 + COEF_FRAC;
   localparam int RW    = PRW - SHIFT;
   localparam int XW    = RW + 1;
   localparam int SW    = T + 6;

   logic en;

   // stage 0: sign and magnitude
   logic          v0_ff;
   sector_type    sec0_ff;
   logic          sx0_ff, sy0_ff;
   logic [MW-1:0] mx0_ff, my0_ff;

   // stage 1: partial products
   logic            v1_ff;
   sector_type      sec1_ff;
   logic            sx1_ff, sy1_ff;
   logic [HW+T-1:0] pxh_ff, pyh_ff;
   logic [H+T-1:0]  pxl_ff, pyl_ff;

   // stage 2: truncated on-time magnitudes
   logic           v2_ff;
   sector_type     sec2_ff;
   logic           sx2_ff, sy2_ff;
   logic [RW-1:0]  rx2_ff, ry2_ff;
   logic [PRW-1:0] sumx, sumy;

   // stage 3: signed on-times and zero time
   logic                 v3_ff;
   sector_type           sec3_ff;
   logic signed [XW-1:0] x3_ff, y3_ff, x3_in, y3_in;
   logic signed [SW-1:0] s3_ff, s3_in;

   // stage 4: phase timings in build-up order
   logic                 v4_ff;
   sector_type           sec4_ff;
   logic signed [SW-1:0] t0_ff, t1_ff, t2_ff, t0_in, t1_in, t2_in;
   logic signed [XW-1:0] first, second;

   // output register
   logic             rsp_valid_ff;
   logic [T-1:0]     duty_a_ff, duty_b_ff, duty_c_ff, duty_a_in, duty_b_in, duty_c_in;
   logic [T-1:0]     c0, c1, c2;
   sector_type       sector_ff;

   function automatic logic [T-1:0] clamp_time(input logic signed [SW-1:0] t,
                                               input logic [T-1:0] hp);
      logic [T-1:0] r;
      if (t <= 0) begin
         r = '0;
      end else if (t > $signed(SW'(hp))) begin
         r = hp;
      end else begin
         r = t[T-1:0];
      end
      return r;
   endfunction

   // the whole pipe holds while a result waits
   assign en  = !(rsp_valid_ff && rsp_stall);
   assign pop = en && !queue_empty;

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff        <= 1'b0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         v0_ff        <= !queue_empty;
         v1_ff        <= v0_ff;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         v4_ff        <= v3_ff;
         rsp_valid_ff <= v4_ff;
      end
   end

   // product sums and shift to whole counts
   assign sumx = (PRW'(pxh_ff) << H) + PRW'(pxl_ff);
   assign sumy = (PRW'(pyh_ff) << H) + PRW'(pyl_ff);

   // signed on-times and zero time
   always_comb begin
      x3_in = sx2_ff ? -$signed(XW'(rx2_ff)) : $signed(XW'(rx2_ff));
      y3_in = sy2_ff ? -$signed(XW'(ry2_ff)) : $signed(XW'(ry2_ff));
      s3_in = $signed(SW'(half_period)) - SW'(x3_in) - SW'(y3_in);
   end

   // half the zero time toward zero, then the other two timings
   always_comb begin
      if (sec3_ff == SECTOR_1 || sec3_ff == SECTOR_3 || sec3_ff == SECTOR_5) begin
         first  = x3_ff;
         second = y3_ff;
      end else begin
         first  = y3_ff;
         second = x3_ff;
      end
      t0_in = (s3_ff + $signed({{(SW-1){1'b0}}, s3_ff[SW-1]})) >>> 1;
      t1_in = t0_in + SW'(first);
      t2_in = t1_in + SW'(second);
   end

   // saturate and place the timings on the phases
   always_comb begin
      c0 = clamp_time(t0_ff, half_period);
      c1 = clamp_time(t1_ff, half_period);
      c2 = clamp_time(t2_ff, half_period);
      unique case (sec4_ff)
         SECTOR_1: begin
            duty_a_in = c0;
            duty_b_in = c1;
            duty_c_in = c2;
         end
         SECTOR_2: begin
            duty_b_in = c0;
            duty_a_in = c1;
            duty_c_in = c2;
         end
         SECTOR_3: begin
            duty_b_in = c0;
            duty_c_in = c1;
            duty_a_in = c2;
         end
         SECTOR_4: begin
            duty_c_in = c0;
            duty_b_in = c1;
            duty_a_in = c2;
         end
         SECTOR_5: begin
            duty_c_in = c0;
            duty_a_in = c1;
            duty_b_in = c2;
         end
         default: begin
            duty_a_in = c0;
            duty_c_in = c1;
            duty_b_in = c2;
         end
      endcase
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (en) begin
         sec0_ff   <= pop_sector;
         sx0_ff    <= pop_x[LW-1];
         sy0_ff    <= pop_y[LW-1];
         mx0_ff    <= pop_x[LW-1] ? MW'(-pop_x) : MW'(pop_x);
         my0_ff    <= pop_y[LW-1] ? MW'(-pop_y) : MW'(pop_y);

         sec1_ff   <= sec0_ff;
         sx1_ff    <= sx0_ff;
         sy1_ff    <= sy0_ff;
         pxh_ff    <= mx0_ff[MW-1:H] * half_period;
         pxl_ff    <= mx0_ff[H-1:0] * half_period;
         pyh_ff    <= my0_ff[MW-1:H] * half_period;
         pyl_ff    <= my0_ff[H-1:0] * half_period;

         sec2_ff   <= sec1_ff;
         sx2_ff    <= sx1_ff;
         sy2_ff    <= sy1_ff;
         rx2_ff    <= sumx[PRW-1:SHIFT];
         ry2_ff    <= sumy[PRW-1:SHIFT];

         sec3_ff   <= sec2_ff;
         x3_ff     <= x3_in;
         y3_ff     <= y3_in;
         s3_ff     <= s3_in;

         sec4_ff   <= sec3_ff;
         t0_ff     <= t0_in;
         t1_ff     <= t1_in;
         t2_ff     <= t2_in;

         sector_ff <= sec4_ff;
         duty_a_ff <= duty_a_in;
         duty_b_ff <= duty_b_in;
         duty_c_ff <= duty_c_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_duty_a = duty_a_ff;
   assign rsp_duty_b = duty_b_ff;
   assign rsp_duty_c = duty_c_ff;
   assign rsp_sector = sector_ff;

endmodule

[design/space_vector_pwm_timing.sv]
// Top level of the space vector PWM timing block.
// Throughput: one item per cycle while the output is not stalled; the depth is the front stage
// register, one queue slot and six back-end stages (magnitude, split products, truncation,
// zero time, build-up, output).
// A 4-entry queue between sector classification and timing absorbs output stalls.
// Reset (synchronous, active high) empties the pipe and queue and loads half_period 10000.
module space_vector_pwm_timing #(
   parameter int VEC_WIDTH   = 16,
   parameter int TIMER_WIDTH = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [TIMER_WIDTH-1:0]      csr_data,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic signed [VEC_WIDTH-1:0] req_alpha,
   input  logic signed [VEC_WIDTH-1:0] req_beta,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [TIMER_WIDTH-1:0]      rsp_duty_a,
   output logic [TIMER_WIDTH-1:0]      rsp_duty_b,
   output logic [TIMER_WIDTH-1:0]      rsp_duty_c,
   output logic [2:0]                  rsp_sector
);
   import svpwm_pkg::*;

   localparam int LW = VEC_WIDTH + COEF_WIDTH;
   localparam int SECW = $bits(sector_type);
   localparam int QW = SECW + 2 * LW;

   logic [TIMER_WIDTH-1:0] half_period_ff;
   logic                   push, pop, queue_full, queue_empty;
   sector_type             push_sector, pop_sector;
   logic signed [LW-1:0]   push_x, push_y, pop_x, pop_y;
   logic [QW-1:0]          push_data, pop_data;

   // timer top count register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         half_period_ff <= TIMER_WIDTH'(HALF_PERIOD_RESET);
      end else if (csr_valid && csr_ready) begin
         half_period_ff <= csr_data;
      end
   end

   svpwm_front #(
      .VEC_WIDTH (VEC_WIDTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_alpha   (req_alpha),
      .req_beta    (req_beta),
      .queue_full  (queue_full),
      .push        (push),
      .push_sector (push_sector),
      .push_x      (push_x),
      .push_y      (push_y)
   );

   // pack and unpack queue entries
   assign push_data  = {push_sector, push_x, push_y};
   assign pop_sector = sector_type'(pop_data[QW-1 -: SECW]);
   assign pop_x      = pop_data[2*LW-1 -: LW];
   assign pop_y      = pop_data[LW-1:0];

   svpwm_queue #(
      .DATA_WIDTH (QW),
      .DEPTH      (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (queue_empty)
   );

   svpwm_back #(
      .VEC_WIDTH   (VEC_WIDTH),
      .TIMER_WIDTH (TIMER_WIDTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .half_period (half_period_ff),
      .queue_empty (queue_empty),
      .pop         (pop),
      .pop_sector  (pop_sector),
      .pop_x       (pop_x),
      .pop_y       (pop_y),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_duty_a  (rsp_duty_a),
      .rsp_duty_b  (rsp_duty_b),
      .rsp_duty_c  (rsp_duty_c),
      .rsp_sector  (rsp_sector)
   );

endmodule

[design/svpwm_checker.sv]
// port-level checks for the space vector pwm timing block, bound to the top level
module svpwm_checker #(
   parameter int TIMER_WIDTH = 16
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input logic [TIMER_WIDTH-1:0] rsp_duty_a,
   input logic [TIMER_WIDTH-1:0] rsp_duty_b,
   input logic [TIMER_WIDTH-1:0] rsp_duty_c,
   input logic [2:0]             rsp_sector
);
   import svpwm_pkg::*;

   // reset leaves no result pending
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid &&
         $stable({rsp_duty_a, rsp_duty_b, rsp_duty_c, rsp_sector}))
      else $error("stalled result changed");

   // sector is always one to six
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_sector >= SECTOR_1 && rsp_sector <= SECTOR_6))
      else $error("sector out of range");

   // in the first sector the phase timings rise from a to c
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_sector == SECTOR_1 |->
         (rsp_duty_a <= rsp_duty_b && rsp_duty_b <= rsp_duty_c))
      else $error("phase order wrong in first sector");

endmodule

bind space_vector_pwm_timing svpwm_checker #(.TIMER_WIDTH(TIMER_WIDTH)) u_checker (.*);
